### design/terh_pkg.sv
// Shared constants, types and helper functions of the tile exponent range histogram.
package terh_pkg;

	localparam int NUM_BINS      = 19;
	localparam int BIN_W         = 5;
	localparam int CNT_W         = 32;
	localparam int EXP_W         = 8;
	localparam int SIDE_W        = 4;
	localparam int ELEM_W        = 6;
	localparam int TZ_W          = 7;
	localparam int SIZE_W        = 7;
	localparam int OP_W          = 2;
	localparam int VALUE_W       = 32;
	localparam int REG_IDX_W     = 2;
	localparam int MAX_TILE_SIDE = 8;

	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic KIND_TILE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_ZERO_EXP  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TILE_SIDE = 2'd1;

	localparam logic [EXP_W-1:0]  ZERO_EXP_RESET  = 8'd1;
	localparam logic [SIDE_W-1:0] TILE_SIDE_RESET = 4'd4;
	localparam logic [EXP_W-1:0]  MIN_EXP_RESET   = 8'hFF;
	localparam logic [EXP_W-1:0]  WIDE_LIMIT      = 8'd16;
	localparam logic [BIN_W-1:0]  ZERO_TILE_RANGE = 5'd12;
	localparam logic [BIN_W-1:0]  WIDE_RANGE      = 5'd18;
	localparam logic [BIN_W-1:0]  LAST_BIN        = BIN_W'(NUM_BINS - 1);
	localparam int                EXP_LSB         = 23;

	typedef logic [CNT_W-1:0] count_t;

	// Write port of the histogram store; clr empties every bin at once.
	typedef struct packed {
		logic             en;
		logic             clr;
		logic [BIN_W-1:0] addr;
		count_t           data;
	} hist_wr_t;

	function automatic count_t sat_inc(input count_t c);
		return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
	endfunction

	// Side zero acts as one, sides beyond the maximum are clamped.
	function automatic logic [SIZE_W-1:0] tile_size(input logic [SIDE_W-1:0] side);
		logic [SIZE_W-1:0] s;
		s = SIZE_W'(side);
		if (side == '0) begin
			s = SIZE_W'(1);
		end else if (side > SIDE_W'(MAX_TILE_SIDE)) begin
			s = SIZE_W'(MAX_TILE_SIDE);
		end
		return SIZE_W'(s * s);
	endfunction

endpackage

### design/terh_if.sv
// Handshake channel interfaces: sample input, result output and register write.
interface terh_in_if;
	logic                            valid;
	logic                            ready;
	logic [terh_pkg::OP_W-1:0]       operation;
	logic [terh_pkg::VALUE_W-1:0]    value_bits;
	logic [terh_pkg::BIN_W-1:0]      bin_index;
	modport source(output valid, operation, value_bits, bin_index, input ready);
	modport sink(input valid, operation, value_bits, bin_index, output ready);
endinterface

interface terh_out_if;
	logic                         valid;
	logic                         ready;
	logic                         result_kind;
	logic [terh_pkg::BIN_W-1:0]   exponent_range;
	logic                         zero_tile;
	logic                         wide_range;
	logic [terh_pkg::TZ_W-1:0]    tile_zero_values;
	terh_pkg::count_t             bin_count;
	terh_pkg::count_t             total_zero_values;
	terh_pkg::count_t             total_tiles;
	terh_pkg::count_t             zero_tile_count;
	terh_pkg::count_t             wide_tile_count;
	modport source(output valid, result_kind, exponent_range, zero_tile, wide_range,
		tile_zero_values, bin_count, total_zero_values, total_tiles, zero_tile_count,
		wide_tile_count, input ready);
	modport sink(input valid, result_kind, exponent_range, zero_tile, wide_range,
		tile_zero_values, bin_count, total_zero_values, total_tiles, zero_tile_count,
		wide_tile_count, output ready);
endinterface

interface terh_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [terh_pkg::REG_IDX_W-1:0]  index;
	logic [terh_pkg::EXP_W-1:0]      data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### design/tile_exponent_range_histogram.sv
// Top level of the tile exponent range histogram.
// An item's result passes the stage-1 register and then the output register after its
// accepting beat, and is held on the output until it is taken.
// Throughput: one item per cycle unless stalled; the 19-bin histogram is read when an
// item is accepted and written back from stage 1, with forwarding between neighbors.
// The input stalls only while a finished result is held at the output unread.
// Reset clears the histogram, totals and tile in progress, and loads the registers.
module tile_exponent_range_histogram (
	input  logic          clk,
	input  logic          arst_n,
	terh_in_if.sink       samples,
	terh_out_if.source    results,
	terh_cfg_if.sink      cfg
);

	logic [terh_pkg::EXP_W-1:0]   zero_exp_q;
	logic [terh_pkg::SIDE_W-1:0]  tile_side_q;

	logic [terh_pkg::ELEM_W-1:0]  elem_q;
	logic [terh_pkg::EXP_W-1:0]   min_q;
	logic [terh_pkg::EXP_W-1:0]   max_q;
	logic [terh_pkg::TZ_W-1:0]    tz_q;

	logic                         stall;
	logic                         advance;
	logic                         accept;
	logic                         is_sample;
	logic                         is_read;
	logic                         is_clear;
	logic [terh_pkg::EXP_W-1:0]   e;
	logic [terh_pkg::EXP_W-1:0]   min_n;
	logic [terh_pkg::EXP_W-1:0]   max_n;
	logic [terh_pkg::EXP_W-1:0]   min_clamped;
	logic [terh_pkg::EXP_W-1:0]   diff;
	logic                         below_zero;
	logic [terh_pkg::TZ_W-1:0]    tz_n;
	logic [terh_pkg::SIZE_W-1:0]  elem_p1;
	logic                         tile_end;
	logic                         ztile;
	logic                         wide;
	logic [terh_pkg::BIN_W-1:0]   range_c;
	logic                         bin_ok;
	logic                         rd_en;
	logic [terh_pkg::BIN_W-1:0]   rd_addr;

	logic                         s1_valid_q;
	logic [terh_pkg::OP_W-1:0]    op_s1;
	logic                         tile_end_s1;
	logic                         zinc_s1;
	logic [terh_pkg::BIN_W-1:0]   range_s1;
	logic                         ztile_s1;
	logic                         wide_s1;
	logic [terh_pkg::TZ_W-1:0]    tz_s1;
	logic                         bin_ok_s1;

	logic                         do_clr;
	logic                         do_tile;
	logic                         do_read;
	terh_pkg::count_t             count;
	terh_pkg::count_t             new_count;
	terh_pkg::hist_wr_t           wr;

	terh_pkg::count_t             zero_total_q;
	terh_pkg::count_t             tile_total_q;
	terh_pkg::count_t             ztile_total_q;
	terh_pkg::count_t             wide_total_q;
	terh_pkg::count_t             zero_total_n;
	terh_pkg::count_t             tile_total_n;
	terh_pkg::count_t             ztile_total_n;
	terh_pkg::count_t             wide_total_n;

	logic                         out_valid_q;
	logic                         kind_q;
	logic [terh_pkg::BIN_W-1:0]   range_q;
	logic                         ztile_q;
	logic                         wide_q;
	logic [terh_pkg::TZ_W-1:0]    tz_out_q;
	terh_pkg::count_t             bin_count_q;
	terh_pkg::count_t             out_zero_total_q;
	terh_pkg::count_t             out_tile_total_q;
	terh_pkg::count_t             out_ztile_total_q;
	terh_pkg::count_t             out_wide_total_q;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_exp_q  <= terh_pkg::ZERO_EXP_RESET;
			tile_side_q <= terh_pkg::TILE_SIDE_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == terh_pkg::REG_ZERO_EXP) begin
				zero_exp_q <= cfg.data;
			end else if (cfg.index == terh_pkg::REG_TILE_SIDE) begin
				tile_side_q <= cfg.data[terh_pkg::SIDE_W-1:0];
			end
		end
	end

	// Input handshake: the pipeline moves unless a result waits at the output.
	assign stall         = out_valid_q && !results.ready;
	assign advance       = !stall;
	assign samples.ready = advance;
	assign accept        = samples.valid && advance;

	assign is_sample = samples.operation == terh_pkg::OP_SAMPLE;
	assign is_read   = samples.operation == terh_pkg::OP_READ;
	assign is_clear  = samples.operation == terh_pkg::OP_CLEAR;

	// Per-value tile tracking and end-of-tile range, all on 8-bit exponents.
	always_comb begin
		e           = samples.value_bits[terh_pkg::EXP_LSB +: terh_pkg::EXP_W];
		min_n       = (e < min_q) ? e : min_q;
		max_n       = (e > max_q) ? e : max_q;
		below_zero  = e < zero_exp_q;
		tz_n        = (below_zero && tz_q != '1) ? tz_q + 1'b1 : tz_q;
		elem_p1     = {1'b0, elem_q} + 1'b1;
		tile_end    = elem_p1 >= terh_pkg::tile_size(tile_side_q);
		min_clamped = (min_n < zero_exp_q) ? zero_exp_q : min_n;
		ztile       = max_n < zero_exp_q;
		diff        = max_n - min_clamped;
		wide        = !ztile && diff > terh_pkg::WIDE_LIMIT;
		if (ztile) begin
			range_c = terh_pkg::ZERO_TILE_RANGE;
		end else if (wide) begin
			range_c = terh_pkg::WIDE_RANGE;
		end else begin
			range_c = diff[terh_pkg::BIN_W-1:0];
		end
		bin_ok  = samples.bin_index <= terh_pkg::LAST_BIN;
		rd_en   = accept && ((is_sample && tile_end) || (is_read && bin_ok));
		rd_addr = is_sample ? range_c : samples.bin_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q <= '0;
			min_q  <= terh_pkg::MIN_EXP_RESET;
			max_q  <= '0;
			tz_q   <= '0;
		end else if (accept) begin
			if (is_clear || (is_sample && tile_end)) begin
				elem_q <= '0;
				min_q  <= terh_pkg::MIN_EXP_RESET;
				max_q  <= '0;
				tz_q   <= '0;
			end else if (is_sample) begin
				elem_q <= (elem_q == '1) ? elem_q : elem_q + 1'b1;
				min_q  <= min_n;
				max_q  <= max_n;
				tz_q   <= tz_n;
			end
		end
	end

	// Stage 1: histogram read returns, totals and the bin are updated.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= samples.operation;
			tile_end_s1 <= tile_end;
			zinc_s1     <= below_zero;
			range_s1    <= range_c;
			ztile_s1    <= ztile;
			wide_s1     <= wide;
			tz_s1       <= tz_n;
			bin_ok_s1   <= bin_ok;
		end
	end

	terh_hist_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.advance (advance),
		.wr      (wr),
		.count   (count)
	);

	always_comb begin
		do_clr    = s1_valid_q && op_s1 == terh_pkg::OP_CLEAR;
		do_read   = s1_valid_q && op_s1 == terh_pkg::OP_READ;
		do_tile   = s1_valid_q && op_s1 == terh_pkg::OP_SAMPLE && tile_end_s1;
		new_count = terh_pkg::sat_inc(count);
		wr.en     = advance && do_tile;
		wr.clr    = advance && do_clr;
		wr.addr   = range_s1;
		wr.data   = new_count;
		zero_total_n  = (s1_valid_q && op_s1 == terh_pkg::OP_SAMPLE && zinc_s1) ?
			terh_pkg::sat_inc(zero_total_q) : zero_total_q;
		tile_total_n  = do_tile ? terh_pkg::sat_inc(tile_total_q) : tile_total_q;
		ztile_total_n = (do_tile && ztile_s1) ?
			terh_pkg::sat_inc(ztile_total_q) : ztile_total_q;
		wide_total_n  = (do_tile && wide_s1) ?
			terh_pkg::sat_inc(wide_total_q) : wide_total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_total_q  <= '0;
			tile_total_q  <= '0;
			ztile_total_q <= '0;
			wide_total_q  <= '0;
		end else if (advance) begin
			if (do_clr) begin
				zero_total_q  <= '0;
				tile_total_q  <= '0;
				ztile_total_q <= '0;
				wide_total_q  <= '0;
			end else begin
				zero_total_q  <= zero_total_n;
				tile_total_q  <= tile_total_n;
				ztile_total_q <= ztile_total_n;
				wide_total_q  <= wide_total_n;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= do_tile || do_read;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (do_tile || do_read)) begin
			kind_q            <= do_tile ? terh_pkg::KIND_TILE : terh_pkg::KIND_READ;
			range_q           <= do_tile ? range_s1 : '0;
			ztile_q           <= do_tile && ztile_s1;
			wide_q            <= do_tile && wide_s1;
			tz_out_q          <= do_tile ? tz_s1 : '0;
			bin_count_q       <= do_tile ? new_count : (bin_ok_s1 ? count : '0);
			out_zero_total_q  <= zero_total_n;
			out_tile_total_q  <= tile_total_n;
			out_ztile_total_q <= ztile_total_n;
			out_wide_total_q  <= wide_total_n;
		end
	end

	assign results.valid             = out_valid_q;
	assign results.result_kind       = kind_q;
	assign results.exponent_range    = range_q;
	assign results.zero_tile         = ztile_q;
	assign results.wide_range        = wide_q;
	assign results.tile_zero_values  = tz_out_q;
	assign results.bin_count         = bin_count_q;
	assign results.total_zero_values = out_zero_total_q;
	assign results.total_tiles       = out_tile_total_q;
	assign results.zero_tile_count   = out_ztile_total_q;
	assign results.wide_tile_count   = out_wide_total_q;

	a_zero_tile_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == terh_pkg::KIND_TILE && ztile_q |->
		range_q == terh_pkg::ZERO_TILE_RANGE)
		else $error("zero tile reported with a range other than the zero-tile range");

	a_wide_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && wide_q |-> range_q == terh_pkg::WIDE_RANGE && !ztile_q)
		else $error("wide tile reported with a wrong range");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == terh_pkg::KIND_READ |->
		range_q == '0 && !ztile_q && !wide_q && tz_out_q == '0)
		else $error("read reply carries tile fields");

	a_clear_totals: assert property (@(posedge clk) disable iff (!arst_n)
		advance && do_clr |=> tile_total_q == '0 && zero_total_q == '0 &&
		ztile_total_q == '0 && wide_total_q == '0)
		else $error("totals not emptied by clear");

	a_tile_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && do_tile && tile_total_q != '1 |=>
		tile_total_q == $past(tile_total_q) + 1'b1)
		else $error("tile total did not advance on a finished tile");

endmodule

### design/terh_hist_store.sv
// Histogram bin memory with per-bin valid bits and write-to-read forwarding.
module terh_hist_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [terh_pkg::BIN_W-1:0] rd_addr,
	input  logic                       advance,
	input  terh_pkg::hist_wr_t         wr,
	output terh_pkg::count_t           count
);

	terh_pkg::count_t                mem [terh_pkg::NUM_BINS];
	terh_pkg::count_t                rdata_s1;
	logic [terh_pkg::BIN_W-1:0]      addr_s1;
	logic [terh_pkg::NUM_BINS-1:0]   bin_valid_q;
	logic                            fwd_valid_q;
	logic [terh_pkg::BIN_W-1:0]      fwd_addr_q;
	terh_pkg::count_t                fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
			addr_s1  <= rd_addr;
		end
	end

	// A read issued on the edge of a write sees the old word; the last write is
	// kept until the next item moves on so that it can be forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (wr.clr) begin
				bin_valid_q <= '0;
			end else if (wr.en) begin
				bin_valid_q[wr.addr] <= 1'b1;
			end
			if (advance) begin
				fwd_valid_q <= wr.en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_addr_q <= wr.addr;
			fwd_data_q <= wr.data;
		end
	end

	always_comb begin
		if (fwd_valid_q && fwd_addr_q == addr_s1) begin
			count = fwd_data_q;
		end else if (bin_valid_q[addr_s1]) begin
			count = rdata_s1;
		end else begin
			count = '0;
		end
	end

endmodule
